[rtl/cts_pkg.sv]
package cts_pkg;

	localparam int XTE_W      = 25;
	localparam int CDEG_W     = 16;
	localparam int ISUM_W     = 26;
	localparam int PROD_W     = 43;
	localparam int SUM_W      = 44;
	localparam int CV_W       = 48;
	localparam int Z_W        = 24;
	localparam int ATAN_N     = 24;
	localparam int ITER_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OP_W       = 4;

	localparam int CORDIC_STEPS_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOK  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd5;

	localparam logic [15:0] KI_RST    = 16'd4096;
	localparam logic [15:0] KD_RST    = 16'd4096;
	localparam logic [6:0]  MAXA_RST  = 7'd30;
	localparam logic [13:0] STEP_RST  = 14'd2000;
	localparam logic [16:0] LOOK_RST  = 17'd5000;
	localparam logic [23:0] LIMIT_RST = 24'd2500;

	// floor(a/5) = (a*RECIP5)>>18 for a < 2^17
	localparam logic [15:0] RECIP5 = 16'd52429;
	// floor(m*17453/10000) = (m*HW_MUL)>>30 for m < 36000
	localparam logic [30:0] HW_MUL = 31'd1874001607;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_WIN    = 4'd2;
	localparam logic [OP_W-1:0] OP_ACC    = 4'd3;
	localparam logic [OP_W-1:0] OP_CLAMP  = 4'd4;
	localparam logic [OP_W-1:0] OP_MULI   = 4'd5;
	localparam logic [OP_W-1:0] OP_MULD   = 4'd6;
	localparam logic [OP_W-1:0] OP_SUM    = 4'd7;
	localparam logic [OP_W-1:0] OP_ITER   = 4'd8;
	localparam logic [OP_W-1:0] OP_ROUND  = 4'd9;
	localparam logic [OP_W-1:0] OP_CLIP   = 4'd10;
	localparam logic [OP_W-1:0] OP_TURN   = 4'd11;
	localparam logic [OP_W-1:0] OP_STEER  = 4'd12;
	localparam logic [OP_W-1:0] OP_MAG    = 4'd13;
	localparam logic [OP_W-1:0] OP_WORD   = 4'd14;
	localparam logic [OP_W-1:0] OP_FINISH = 4'd15;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cts_cmd_t;

	typedef struct packed {
		logic gate;
		logic cordic_last;
		logic out_free;
	} cts_stat_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
		logic [Z_W-1:0] r;
		case (i)
			5'd0:  r = 24'd2949120;
			5'd1:  r = 24'd1740967;
			5'd2:  r = 24'd919879;
			5'd3:  r = 24'd466945;
			5'd4:  r = 24'd234379;
			5'd5:  r = 24'd117304;
			5'd6:  r = 24'd58666;
			5'd7:  r = 24'd29335;
			5'd8:  r = 24'd14668;
			5'd9:  r = 24'd7334;
			5'd10: r = 24'd3667;
			5'd11: r = 24'd1833;
			5'd12: r = 24'd917;
			5'd13: r = 24'd458;
			5'd14: r = 24'd229;
			5'd15: r = 24'd115;
			5'd16: r = 24'd57;
			5'd17: r = 24'd29;
			5'd18: r = 24'd14;
			5'd19: r = 24'd7;
			5'd20: r = 24'd4;
			5'd21: r = 24'd2;
			5'd22: r = 24'd1;
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	// reduce into 0..35999 for inputs in -36000..107999
	function automatic logic [CDEG_W-1:0] wrap_cdeg(input logic signed [18:0] v);
		logic signed [18:0] r;
		if (v < 19'sd0)
			r = v + 19'sd36000;
		else if (v >= 19'sd72000)
			r = v - 19'sd72000;
		else if (v >= 19'sd36000)
			r = v - 19'sd36000;
		else
			r = v;
		return r[CDEG_W-1:0];
	endfunction

endpackage

[rtl/cts_ctrl.sv]
module cts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cts_pkg::cts_stat_t stat,
	output cts_pkg::cts_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WIN   = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_CLAMP = 4'd3;
	localparam logic [3:0] ST_MULI  = 4'd4;
	localparam logic [3:0] ST_MULD  = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_ITER  = 4'd7;
	localparam logic [3:0] ST_ROUND = 4'd8;
	localparam logic [3:0] ST_CLIP  = 4'd9;
	localparam logic [3:0] ST_TURN  = 4'd10;
	localparam logic [3:0] ST_STEER = 4'd11;
	localparam logic [3:0] ST_MAG   = 4'd12;
	localparam logic [3:0] ST_WORD  = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = cts_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = cts_pkg::OP_LOAD;
					state_d = stat.gate ? ST_WIN : ST_IDLE;
				end
			end
			ST_WIN:   begin cmd.op = cts_pkg::OP_WIN;   state_d = ST_ACC;   end
			ST_ACC:   begin cmd.op = cts_pkg::OP_ACC;   state_d = ST_CLAMP; end
			ST_CLAMP: begin cmd.op = cts_pkg::OP_CLAMP; state_d = ST_MULI;  end
			ST_MULI:  begin cmd.op = cts_pkg::OP_MULI;  state_d = ST_MULD;  end
			ST_MULD:  begin cmd.op = cts_pkg::OP_MULD;  state_d = ST_SUM;   end
			ST_SUM:   begin cmd.op = cts_pkg::OP_SUM;   state_d = ST_ITER;  end
			ST_ITER: begin
				cmd.op = cts_pkg::OP_ITER;
				if (stat.cordic_last)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin cmd.op = cts_pkg::OP_ROUND; state_d = ST_CLIP;  end
			ST_CLIP:  begin cmd.op = cts_pkg::OP_CLIP;  state_d = ST_TURN;  end
			ST_TURN:  begin cmd.op = cts_pkg::OP_TURN;  state_d = ST_STEER; end
			ST_STEER: begin cmd.op = cts_pkg::OP_STEER; state_d = ST_MAG;   end
			ST_MAG:   begin cmd.op = cts_pkg::OP_MAG;   state_d = ST_WORD;  end
			ST_WORD:  begin cmd.op = cts_pkg::OP_WORD;  state_d = ST_DONE;  end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.op  = cts_pkg::OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[rtl/cts_dp.sv]
module cts_dp #(
	parameter int CORDIC_STEPS = cts_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cts_pkg::cts_cmd_t                    cmd,
	output cts_pkg::cts_stat_t                   stat,
	input  logic                                 cfg_valid,
	input  logic [cts_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cts_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [cts_pkg::XTE_W-1:0]     in_xte,
	input  logic [cts_pkg::CDEG_W-1:0]           in_btw,
	input  logic signed [cts_pkg::CDEG_W-1:0]    in_var,
	input  logic                                 in_leg_valid,
	input  logic                                 in_tracking,
	input  logic                                 in_restart,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [cts_pkg::CDEG_W-1:0]           out_bearing,
	output logic [cts_pkg::CDEG_W-1:0]           out_mag,
	output logic [cts_pkg::CDEG_W-1:0]           out_word,
	output logic                                 out_clipped,
	output logic                                 out_limited
);

	localparam int XW = cts_pkg::XTE_W;
	localparam int IW = cts_pkg::ISUM_W;
	localparam int PW = cts_pkg::PROD_W;
	localparam int SW = cts_pkg::SUM_W;
	localparam int CW = cts_pkg::CV_W;
	localparam int ZW = cts_pkg::Z_W;
	localparam int NW = cts_pkg::ITER_W;

	// configuration
	logic [15:0] ki_q, kd_q;
	logic [6:0]  maxa_q;
	logic [13:0] step_q;
	logic [16:0] look_q;
	logic [23:0] lim_q;

	// loop state
	logic signed [IW-1:0] isum_q;
	logic signed [XW-1:0] prev_q;
	logic [15:0]          cb_q;
	logic                 hs_q;

	// work registers
	logic signed [XW-1:0] x_q, delta_q;
	logic [15:0]          btw_q;
	logic signed [15:0]   var_q;
	logic signed [IW-1:0] d_q;
	logic signed [PW-1:0] pi_q, pd_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] z_q;
	logic [NW-1:0]        iter_q;
	logic                 yzero_q;
	logic signed [15:0]   gamma_q;
	logic                 clip_q;
	logic [15:0]          target_q;
	logic signed [18:0]   turn_q;
	logic [15:0]          rate_q;
	logic                 stepped_q;
	logic [15:0]          mag_q, hw_q;

	logic                 out_valid_q;

	// window
	logic [XW-1:0]  a_abs;
	logic [32:0]    fifth_p;
	logic [XW-1:0]  win_mag;
	logic signed [XW-1:0] win_delta;
	// clamp, sum
	logic signed [IW-1:0] lim_s;
	logic signed [SW-1:0] s_sum;
	// cordic
	logic signed [CW-1:0] sh_x, sh_y;
	logic signed [ZW-1:0] at;
	// round, clip
	logic [ZW-1:0]  z_abs;
	logic [30:0]    rnd_p;
	logic [14:0]    rnd_c;
	logic [13:0]    maxc;
	logic signed [15:0] maxc_s, gamma_c;
	// steering
	logic signed [18:0] turn_raw, turn_adj, rate_s, cb_s, steer_v;
	logic [15:0]    rate_d;
	logic [46:0]    hw_p;

	assign stat.gate        = in_leg_valid & in_tracking;
	assign stat.cordic_last = (iter_q == NW'(CORDIC_STEPS - 1));
	assign stat.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;

	always_comb begin
		a_abs     = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
		fifth_p   = a_abs[16:0] * cts_pkg::RECIP5;
		win_mag   = '0;
		win_delta = '0;
		if ({a_abs, 2'b00} < {10'd0, look_q}) begin
			win_delta = x_q;
		end else begin
			if ({a_abs, 1'b0} < {9'd0, look_q})
				win_mag = {1'b0, a_abs[XW-1:1]};
			else if (a_abs < {8'd0, look_q})
				win_mag = {10'd0, fifth_p[32:18]};
			win_delta = x_q[XW-1] ? -$signed(win_mag) : $signed(win_mag);
		end
	end

	assign lim_s = $signed({2'b00, lim_q});
	assign s_sum = ($signed({{(SW-XW){x_q[XW-1]}}, x_q}) <<< 12)
		+ SW'(pi_q) + SW'(pd_q);

	assign sh_x = cx_q >>> iter_q;
	assign sh_y = cy_q >>> iter_q;
	assign at   = $signed(cts_pkg::atan_lut(iter_q));

	assign z_abs = z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
	assign rnd_p = {7'd0, z_abs} * 31'd100 + 31'd32768;
	assign rnd_c = rnd_p[30:16];

	assign maxc    = {7'd0, maxa_q} * 14'd100;
	assign maxc_s  = $signed({2'b00, maxc});
	assign gamma_c = (gamma_q > maxc_s) ? maxc_s :
		((gamma_q < -maxc_s) ? -maxc_s : gamma_q);

	assign turn_raw = $signed({3'b000, target_q}) - $signed({3'b000, cb_q});
	assign turn_adj = (turn_raw < -19'sd18000) ? turn_raw + 19'sd36000 : turn_raw;
	assign rate_d   = (turn_adj > 19'sd8000 || turn_adj < -19'sd8000) ?
		{1'b0, step_q, 1'b0} : {2'b00, step_q};
	assign rate_s   = $signed({3'b000, rate_q});
	assign cb_s     = $signed({3'b000, cb_q});

	always_comb begin
		if (turn_q < -rate_s || (turn_q > 19'sd18000 && turn_q < 19'sd36000 - rate_s))
			steer_v = cb_s - rate_s;
		else if (turn_q > rate_s && turn_q <= 19'sd18000)
			steer_v = cb_s + rate_s;
		else
			steer_v = $signed({3'b000, target_q});
	end

	assign hw_p = mag_q * cts_pkg::HW_MUL;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ki_q   <= cts_pkg::KI_RST;
			kd_q   <= cts_pkg::KD_RST;
			maxa_q <= cts_pkg::MAXA_RST;
			step_q <= cts_pkg::STEP_RST;
			look_q <= cts_pkg::LOOK_RST;
			lim_q  <= cts_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cts_pkg::CFG_KI:    ki_q   <= cfg_data[15:0];
				cts_pkg::CFG_KD:    kd_q   <= cfg_data[15:0];
				cts_pkg::CFG_MAXA:  maxa_q <= cfg_data[6:0];
				cts_pkg::CFG_STEP:  step_q <= cfg_data[13:0];
				cts_pkg::CFG_LOOK:  look_q <= cfg_data[16:0];
				cts_pkg::CFG_LIMIT: lim_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// loop state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q      <= '0;
			prev_q      <= '0;
			cb_q        <= '0;
			hs_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == cts_pkg::OP_FINISH)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				cts_pkg::OP_LOAD: begin
					if (in_restart) begin
						isum_q <= '0;
						prev_q <= '0;
						hs_q   <= 1'b0;
					end
				end
				cts_pkg::OP_ACC: begin
					isum_q <= isum_q + IW'(delta_q);
					prev_q <= x_q;
				end
				cts_pkg::OP_CLAMP: begin
					if (isum_q > lim_s)
						isum_q <= lim_s;
					else if (isum_q < -lim_s)
						isum_q <= -lim_s;
				end
				cts_pkg::OP_STEER: begin
					hs_q <= 1'b1;
					if (!hs_q)
						cb_q <= target_q;
					else
						cb_q <= cts_pkg::wrap_cdeg(steer_v);
				end
				default: ;
			endcase
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			cts_pkg::OP_LOAD: begin
				x_q   <= in_xte;
				btw_q <= in_btw;
				var_q <= in_var;
			end
			cts_pkg::OP_WIN: delta_q <= win_delta;
			cts_pkg::OP_ACC: d_q <= IW'(x_q) - IW'(prev_q);
			cts_pkg::OP_MULI: pi_q <= $signed({1'b0, ki_q}) * isum_q;
			cts_pkg::OP_MULD: pd_q <= $signed({1'b0, kd_q}) * d_q;
			cts_pkg::OP_SUM: begin
				cx_q    <= $signed({19'd0, look_q, 12'd0});
				cy_q    <= CW'(s_sum);
				z_q     <= '0;
				iter_q  <= '0;
				yzero_q <= (s_sum == '0);
			end
			cts_pkg::OP_ITER: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					z_q  <= z_q + at;
				end else begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					z_q  <= z_q - at;
				end
				iter_q <= iter_q + 1'b1;
			end
			cts_pkg::OP_ROUND: begin
				if (yzero_q)
					gamma_q <= '0;
				else if (z_q[ZW-1])
					gamma_q <= -$signed({1'b0, rnd_c});
				else
					gamma_q <= $signed({1'b0, rnd_c});
			end
			cts_pkg::OP_CLIP: begin
				clip_q   <= (gamma_c != gamma_q);
				target_q <= cts_pkg::wrap_cdeg($signed({3'b000, btw_q}) + 19'(gamma_c));
			end
			cts_pkg::OP_TURN: begin
				turn_q <= turn_adj;
				rate_q <= rate_d;
			end
			cts_pkg::OP_STEER: begin
				stepped_q <= hs_q && (steer_v != $signed({3'b000, target_q}));
			end
			cts_pkg::OP_MAG: mag_q <= cts_pkg::wrap_cdeg(cb_s - 19'(var_q));
			cts_pkg::OP_WORD: hw_q <= hw_p[45:30];
			cts_pkg::OP_FINISH: begin
				out_bearing <= cb_q;
				out_mag     <= mag_q;
				out_word    <= hw_q;
				out_clipped <= clip_q;
				out_limited <= stepped_q;
			end
			default: ;
		endcase
	end

endmodule

[rtl/cross_track_steering_loop.sv]
// A new input transaction is taken only while the sequencer is idle, so the next update
// waits until the current one has been finished; the iterative CORDIC arctangent runs
// one micro-rotation per cycle.
// A finished result waits in the output register while the next update is taken;
// the following result stalls until that one is accepted.
// Reset (arst_n low, asynchronous): configuration registers take their defaults, loop state and output valid clear.
module cross_track_steering_loop #(
	parameter int CORDIC_STEPS = cts_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input update stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [63:0]                         s_tdata,  // xte_cm[24:0], btw_cdeg[40:25],
	                                                      // var_cdeg[56:41], zero pad
	input  logic [2:0]                          s_tuser,  // leg_valid[0], tracking[1], restart[2]
	// steering command stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata,  // bearing_true_cdeg[15:0],
	                                                      // heading_mag_cdeg[31:16],
	                                                      // heading_word[47:32]
	output logic [1:0]                          m_tuser,  // angle_clipped[0], rate_limited[1]
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cts_pkg::CFG_DATA_W-1:0]      cfg_data
);

	cts_pkg::cts_cmd_t  cmd;
	cts_pkg::cts_stat_t stat;

	logic [15:0] out_bearing, out_mag, out_word;
	logic        out_clipped, out_limited;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: accept, gate, walk the datapath through its steps
	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// integrator, PID sum, CORDIC, clip, rate limit, heading conversion
	cts_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_xte       ($signed(s_tdata[24:0])),
		.in_btw       (s_tdata[40:25]),
		.in_var       ($signed(s_tdata[56:41])),
		.in_leg_valid (s_tuser[0]),
		.in_tracking  (s_tuser[1]),
		.in_restart   (s_tuser[2]),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.out_bearing  (out_bearing),
		.out_mag      (out_mag),
		.out_word     (out_word),
		.out_clipped  (out_clipped),
		.out_limited  (out_limited)
	);

	// pack the result transaction
	assign m_tdata = {out_word, out_mag, out_bearing};
	assign m_tuser = {out_limited, out_clipped};

endmodule
